// File: hdl/kde4d_pkg.sv
// ----------------------------------------------------------------------------
// kde4d_pkg
// Shared types and constants of the 4D kernel density grid splat unit.
// ----------------------------------------------------------------------------
package kde4d_pkg;

    localparam int CELLS_X1 = 16;
    localparam int CELLS_Y1 = 16;
    localparam int CELLS_X2 = 16;
    localparam int CELLS_Y2 = 16;

    localparam int PLANE1_CELLS = CELLS_X1 * CELLS_Y1;
    localparam int PLANE2_CELLS = CELLS_X2 * CELLS_Y2;
    localparam longint TOTAL_CELLS = longint'(PLANE1_CELLS) * longint'(PLANE2_CELLS);

    localparam int GRID_DEPTH = 65536;
    localparam int GRID_AW    = 16;
    localparam int IDX_W      = 33;

    localparam int MAX_AXIS = (CELLS_X1 > CELLS_Y1 ? CELLS_X1 : CELLS_Y1) >
                              (CELLS_X2 > CELLS_Y2 ? CELLS_X2 : CELLS_Y2) ?
                              (CELLS_X1 > CELLS_Y1 ? CELLS_X1 : CELLS_Y1) :
                              (CELLS_X2 > CELLS_Y2 ? CELLS_X2 : CELLS_Y2);
    localparam int AXIS_W = (MAX_AXIS > 1) ? $clog2(MAX_AXIS) : 1;
    localparam int P1_W   = (PLANE1_CELLS > 1) ? $clog2(PLANE1_CELLS) : 1;
    localparam int P2_W   = (PLANE2_CELLS > 1) ? $clog2(PLANE2_CELLS) : 1;

    localparam int WEIGHT_W = 17;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X1 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y2 = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH = 8'd5;

    localparam logic REQ_SPLAT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic              start;
        logic [AXIS_W-1:0] ix;
        logic [AXIS_W-1:0] iy;
    } kde4d_wu_req_t;

    typedef enum logic [2:0] {
        WU_IDLE,
        WU_MUL,
        WU_DIFF,
        WU_SQ,
        WU_SUM,
        WU_DIV
    } kde4d_wu_state_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_W1_GO,
        ST_W1_WAIT,
        ST_W2_GO,
        ST_W2_WAIT,
        ST_SWEEP,
        ST_DRAIN
    } kde4d_state_t;

endpackage

// File: hdl/kde4d_ram.sv
// ----------------------------------------------------------------------------
// kde4d_ram
// Simple dual-port synchronous RAM with one write and one registered read port.
// ----------------------------------------------------------------------------
module kde4d_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/kde4d_weight_unit.sv
// ----------------------------------------------------------------------------
// kde4d_weight_unit
// Computes one plane weight floor(65536*(bw^2-d2)/bw^2) for a cell, with a
// one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module kde4d_weight_unit
    import kde4d_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  kde4d_wu_req_t              req,
    input  logic signed [31:0]         origin_x,
    input  logic signed [31:0]         origin_y,
    input  logic signed [31:0]         px,
    input  logic signed [31:0]         py,
    input  logic [30:0]                cell_size,
    input  logic [30:0]                bandwidth,
    output logic                       done,
    output logic [WEIGHT_W-1:0]        weight
);

    localparam int PW = 31 + AXIS_W;
    localparam int DW = PW + 2;

    kde4d_wu_state_t state_reg, state_next;

    logic [PW-1:0]        prodx_reg, prody_reg;
    logic [61:0]          bw2_reg;
    logic [DW-1:0]        ax_reg, ay_reg;
    logic [61:0]          sqx_reg, sqy_reg;
    logic [61:0]          r_reg;
    logic [WEIGHT_W-1:0]  q_reg;
    logic [4:0]           cnt_reg;
    logic                 done_reg;

    logic signed [DW-1:0] dx, dy;
    logic [62:0]          d2;
    logic [62:0]          r2;
    logic                 far;

    assign dx = DW'(origin_x) + $signed({2'b00, prodx_reg}) - DW'(px);
    assign dy = DW'(origin_y) + $signed({2'b00, prody_reg}) - DW'(py);
    assign d2 = 63'(sqx_reg) + 63'(sqy_reg);
    assign r2 = {r_reg, 1'b0};
    assign far = (ax_reg >= DW'(bandwidth)) || (ay_reg >= DW'(bandwidth));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WU_IDLE: if (req.start) state_next = WU_MUL;
            WU_MUL:  state_next = WU_DIFF;
            WU_DIFF: state_next = WU_SQ;
            WU_SQ:   state_next = far ? WU_IDLE : WU_SUM;
            WU_SUM:  state_next = (d2 >= 63'(bw2_reg)) ? WU_IDLE : WU_DIV;
            WU_DIV:  if (cnt_reg == 5'd15) state_next = WU_IDLE;
            default: state_next = WU_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                WU_SQ:
                begin
                    if (far)
                    begin
                        done_reg <= 1'b1;
                    end
                end
                WU_SUM:
                begin
                    cnt_reg <= '0;
                    if (d2 >= 63'(bw2_reg))
                    begin
                        done_reg <= 1'b1;
                    end
                end
                WU_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        done_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            WU_IDLE:
            begin
                prodx_reg <= PW'(cell_size) * PW'(req.ix);
                prody_reg <= PW'(cell_size) * PW'(req.iy);
            end
            WU_MUL:
            begin
                bw2_reg <= 62'(bandwidth) * 62'(bandwidth);
            end
            WU_DIFF:
            begin
                ax_reg <= dx[DW-1] ? DW'(-dx) : DW'(dx);
                ay_reg <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            end
            WU_SQ:
            begin
                sqx_reg <= 62'(ax_reg[30:0]) * 62'(ax_reg[30:0]);
                sqy_reg <= 62'(ay_reg[30:0]) * 62'(ay_reg[30:0]);
                q_reg   <= '0;
            end
            WU_SUM:
            begin
                if (d2 == 63'd0)
                begin
                    r_reg <= '0;
                    q_reg <= WEIGHT_W'(1);
                end
                else
                begin
                    r_reg <= bw2_reg - 62'(d2);
                    q_reg <= '0;
                end
            end
            WU_DIV:
            begin
                if (r2 >= 63'(bw2_reg))
                begin
                    r_reg <= 62'(r2 - 63'(bw2_reg));
                    q_reg <= {q_reg[WEIGHT_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= 62'(r2);
                    q_reg <= {q_reg[WEIGHT_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign weight = q_reg;

endmodule

// File: hdl/kde_4d_grid_splat_unit.sv
// ----------------------------------------------------------------------------
// kde_4d_grid_splat_unit
// Splats Q16.16 points into a cleared 4D density grid with a product kernel
// and reads back single cells with the running point count.
//
// Channel   Direction  Content
// s_axis    in         tuser: req_type; tdata: pt_x1..pt_y2, cell_index
// m_axis    out        tdata: cell_value, point_count
// cfg       in         cfg_index, cfg_data (register write)
//
// After reset the grid memory is cleared; no request is taken then. A splat
// runs the weight divider for each cell of each plane, then sweeps every
// plane-1 cell for each plane-2 cell with a nonzero weight.
// One request is worked at a time; a waiting result does not block splats.
// ----------------------------------------------------------------------------
module kde_4d_grid_splat_unit
    import kde4d_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [143:0]         s_axis_tdata,  // pt_x1, pt_y1, pt_x2, pt_y2, cell_index
    input  logic                 s_axis_tuser,  // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // cell_value, point_count
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    kde4d_state_t state_reg, state_next;

    logic signed [31:0] origin_x1_reg, origin_y1_reg, origin_x2_reg, origin_y2_reg;
    logic [30:0]        cell_size_reg, bandwidth_reg;

    logic signed [31:0] pt_x1_reg, pt_y1_reg, pt_x2_reg, pt_y2_reg;
    logic [15:0]        rd_idx_reg;
    logic [GRID_AW-1:0] clr_addr_reg;

    logic [AXIS_W-1:0]   ix1_reg, iy1_reg, ix2_reg, iy2_reg;
    logic [P1_W-1:0]     p1_reg;
    logic [P2_W-1:0]     c2_reg;
    logic [WEIGHT_W-1:0] w2_reg;
    logic [31:0]         count_reg;

    logic                out_valid_reg;
    logic [31:0]         out_value_reg, out_count_reg;

    logic                s1_valid_reg, s2_valid_reg;
    logic [GRID_AW-1:0]  s1_addr_reg, s2_addr_reg;
    logic [31:0]         s2_old_reg;
    logic [17:0]         s2_inc_reg;

    logic                accept, out_free, p1_last, c2_last, ix1_last, ix2_last;
    logic                wu_done;
    logic [WEIGHT_W-1:0] wu_weight;
    kde4d_wu_req_t       wu_req;
    logic                wu_plane2;

    logic [IDX_W-1:0]    idx_full;
    logic                in_grid, rd_in_range;

    logic                grid_we, grid_re;
    logic [GRID_AW-1:0]  grid_waddr, grid_raddr;
    logic [31:0]         grid_wdata, grid_rdata;
    logic                w1_we, w1_re;
    logic [WEIGHT_W-1:0] w1_rdata;
    logic [32:0]         sum;
    logic [2*WEIGHT_W-1:0] prod;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign p1_last  = (p1_reg == P1_W'(PLANE1_CELLS - 1));
    assign c2_last  = (c2_reg == P2_W'(PLANE2_CELLS - 1));
    assign ix1_last = (ix1_reg == AXIS_W'(CELLS_X1 - 1));
    assign ix2_last = (ix2_reg == AXIS_W'(CELLS_X2 - 1));
    assign idx_full = IDX_W'(c2_reg) * IDX_W'(PLANE1_CELLS) + IDX_W'(p1_reg);
    assign in_grid  = (idx_full < IDX_W'(GRID_DEPTH));
    assign rd_in_range = (IDX_W'(rd_idx_reg) < IDX_W'(TOTAL_CELLS));

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x1_reg <= '0;
            origin_y1_reg <= '0;
            origin_x2_reg <= '0;
            origin_y2_reg <= '0;
            cell_size_reg <= 31'd65536;
            bandwidth_reg <= 31'd131072;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ORIGIN_X1: origin_x1_reg <= cfg_data;
                CFG_ORIGIN_Y1: origin_y1_reg <= cfg_data;
                CFG_ORIGIN_X2: origin_x2_reg <= cfg_data;
                CFG_ORIGIN_Y2: origin_y2_reg <= cfg_data;
                CFG_CELL_SIZE: cell_size_reg <= cfg_data[30:0];
                CFG_BANDWIDTH: bandwidth_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        grid_re       = 1'b0;
        grid_raddr    = rd_idx_reg;
        w1_we         = 1'b0;
        w1_re         = 1'b0;
        wu_req.start  = 1'b0;
        wu_plane2     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == GRID_AW'(GRID_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (accept)
                begin
                    state_next = (s_axis_tuser == REQ_READ) ? ST_RD_ISSUE : ST_W1_GO;
                end
            end
            ST_RD_ISSUE:
            begin
                grid_re    = 1'b1;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_W1_GO:
            begin
                wu_req.start = 1'b1;
                state_next   = ST_W1_WAIT;
            end
            ST_W1_WAIT:
            begin
                if (wu_done)
                begin
                    w1_we      = 1'b1;
                    state_next = p1_last ? ST_W2_GO : ST_W1_GO;
                end
            end
            ST_W2_GO:
            begin
                wu_plane2    = 1'b1;
                wu_req.start = 1'b1;
                state_next   = ST_W2_WAIT;
            end
            ST_W2_WAIT:
            begin
                wu_plane2 = 1'b1;
                if (wu_done)
                begin
                    if (wu_weight != '0)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = c2_last ? ST_DRAIN : ST_W2_GO;
                    end
                end
            end
            ST_SWEEP:
            begin
                w1_re      = 1'b1;
                grid_re    = in_grid;
                grid_raddr = idx_full[GRID_AW-1:0];
                if (p1_last)
                begin
                    state_next = c2_last ? ST_DRAIN : ST_W2_GO;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        wu_req.ix = wu_plane2 ? ix2_reg : ix1_reg;
        wu_req.iy = wu_plane2 ? iy2_reg : iy1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            ix1_reg       <= '0;
            iy1_reg       <= '0;
            p1_reg        <= '0;
            ix2_reg       <= '0;
            iy2_reg       <= '0;
            c2_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_RD_DATA && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            s1_valid_reg <= (state_reg == ST_SWEEP) && in_grid;
            s2_valid_reg <= s1_valid_reg && (w1_rdata != '0);
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + GRID_AW'(1);
                end
                ST_IDLE:
                begin
                    ix1_reg <= '0;
                    iy1_reg <= '0;
                    p1_reg  <= '0;
                    ix2_reg <= '0;
                    iy2_reg <= '0;
                    c2_reg  <= '0;
                end
                ST_W1_WAIT:
                begin
                    if (wu_done)
                    begin
                        if (p1_last)
                        begin
                            p1_reg <= '0;
                        end
                        else
                        begin
                            p1_reg <= p1_reg + P1_W'(1);
                        end
                        if (ix1_last)
                        begin
                            ix1_reg <= '0;
                            iy1_reg <= iy1_reg + AXIS_W'(1);
                        end
                        else
                        begin
                            ix1_reg <= ix1_reg + AXIS_W'(1);
                        end
                    end
                end
                ST_W2_WAIT, ST_SWEEP:
                begin
                    if ((state_reg == ST_SWEEP && p1_last) ||
                        (state_reg == ST_W2_WAIT && wu_done && wu_weight == '0))
                    begin
                        p1_reg <= '0;
                        if (!c2_last)
                        begin
                            c2_reg <= c2_reg + P2_W'(1);
                            if (ix2_last)
                            begin
                                ix2_reg <= '0;
                                iy2_reg <= iy2_reg + AXIS_W'(1);
                            end
                            else
                            begin
                                ix2_reg <= ix2_reg + AXIS_W'(1);
                            end
                        end
                    end
                    else if (state_reg == ST_SWEEP)
                    begin
                        p1_reg <= p1_reg + P1_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!s1_valid_reg && !s2_valid_reg && count_reg != 32'hFFFF_FFFF)
                    begin
                        count_reg <= count_reg + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_x1_reg  <= s_axis_tdata[31:0];
            pt_y1_reg  <= s_axis_tdata[63:32];
            pt_x2_reg  <= s_axis_tdata[95:64];
            pt_y2_reg  <= s_axis_tdata[127:96];
            rd_idx_reg <= s_axis_tdata[143:128];
        end
        if (state_reg == ST_W2_WAIT && wu_done)
        begin
            w2_reg <= wu_weight;
        end
        if (state_reg == ST_RD_DATA && out_free)
        begin
            out_value_reg <= rd_in_range ? grid_rdata : 32'd0;
            out_count_reg <= count_reg;
        end
        s1_addr_reg <= idx_full[GRID_AW-1:0];
        s2_addr_reg <= s1_addr_reg;
        s2_old_reg  <= grid_rdata;
        s2_inc_reg  <= prod[33:16];
    end

    assign prod = (2*WEIGHT_W)'(w1_rdata) * (2*WEIGHT_W)'(w2_reg);
    assign sum  = 33'(s2_old_reg) + 33'(s2_inc_reg);

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            grid_we    = 1'b1;
            grid_waddr = clr_addr_reg;
            grid_wdata = '0;
        end
        else
        begin
            grid_we    = s2_valid_reg;
            grid_waddr = s2_addr_reg;
            grid_wdata = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
    end

    kde4d_ram #(
        .DEPTH (GRID_DEPTH),
        .WIDTH (32)
    ) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .re    (grid_re),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    kde4d_ram #(
        .DEPTH (PLANE1_CELLS),
        .WIDTH (WEIGHT_W)
    ) u_w1 (
        .clk   (clk),
        .we    (w1_we),
        .waddr (p1_reg),
        .wdata (wu_weight),
        .re    (w1_re),
        .raddr (p1_reg),
        .rdata (w1_rdata)
    );

    kde4d_weight_unit u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (wu_req),
        .origin_x  (wu_plane2 ? origin_x2_reg : origin_x1_reg),
        .origin_y  (wu_plane2 ? origin_y2_reg : origin_y1_reg),
        .px        (wu_plane2 ? pt_x2_reg : pt_x1_reg),
        .py        (wu_plane2 ? pt_y2_reg : pt_y1_reg),
        .cell_size (cell_size_reg),
        .bandwidth (bandwidth_reg),
        .done      (wu_done),
        .weight    (wu_weight)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_value_reg};

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4D kernel density grid splat unit. A queue of
// splat and read requests feeds a stream driver with random gaps, or none in
// one phase. Accepted requests update a local density grid and point count,
// and every returned cell is checked against it.
// ----------------------------------------------------------------------------
module testbench;
    import kde4d_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd60_000_000;

    typedef struct {
        logic        kind;
        logic [31:0] x1;
        logic [31:0] y1;
        logic [31:0] x2;
        logic [31:0] y2;
        logic [15:0] cidx;
    } request_t;

    typedef struct {
        logic [31:0] value;
        logic [31:0] count;
    } cell_read_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [143:0]         s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    request_t    pending_requests[$];
    request_t    on_bus;
    cell_read_t  expected_reads[$];
    int unsigned density[GRID_DEPTH];
    logic [31:0] splat_count = '0;
    logic [31:0] org_x1 = '0, org_y1 = '0, org_x2 = '0, org_y2 = '0;
    logic [30:0] cell_len = 31'd65536;
    logic [30:0] band = 31'd131072;
    logic [15:0] recent_cell = '0;
    bit          taken = 1'b0;
    bit          no_gaps = 1'b0;
    bit          failed = 1'b0;
    longint      cycles = 0;
    int          queued = 0;
    int          accepted = 0;

    kde_4d_grid_splat_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint axis_offset(logic [31:0] org, int i, logic [31:0] p);
        return longint'(signed'(org)) + longint'(cell_len) * i - longint'(signed'(p));
    endfunction

    function automatic int unsigned kernel_weight(longint dx, longint dy);
        longint unsigned ax, ay, b, b2, d2, r;
        int unsigned q;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        b = longint'(band);
        if (ax >= b || ay >= b)
            return 0;
        b2 = b * b;
        d2 = ax * ax + ay * ay;
        if (d2 >= b2)
            return 0;
        r = b2 - d2;
        q = 0;
        if (r >= b2)
        begin
            r -= b2;
            q = 1;
        end
        for (int k = 0; k < 16; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= b2)
            begin
                r -= b2;
                q |= 1;
            end
        end
        return q;
    endfunction

    task automatic splat_point(request_t rq);
        int unsigned w1[PLANE1_CELLS];
        int unsigned w2;
        longint dy;
        longint unsigned idx, sum;
        for (int iy = 0; iy < CELLS_Y1; iy++)
        begin
            dy = axis_offset(org_y1, iy, rq.y1);
            for (int ix = 0; ix < CELLS_X1; ix++)
                w1[ix + iy * CELLS_X1] = kernel_weight(axis_offset(org_x1, ix, rq.x1), dy);
        end
        for (int iy = 0; iy < CELLS_Y2; iy++)
        begin
            dy = axis_offset(org_y2, iy, rq.y2);
            for (int ix = 0; ix < CELLS_X2; ix++)
            begin
                w2 = kernel_weight(axis_offset(org_x2, ix, rq.x2), dy);
                if (w2 != 0)
                begin
                    for (int p = 0; p < PLANE1_CELLS; p++)
                    begin
                        idx = longint'(ix + iy * CELLS_X2) * PLANE1_CELLS + p;
                        if (w1[p] != 0 && idx < GRID_DEPTH)
                        begin
                            sum = longint'(density[idx])
                                + ((longint'(w1[p]) * longint'(w2)) >> 16);
                            density[idx] = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
                        end
                    end
                end
            end
        end
        if (splat_count != 32'hFFFF_FFFF)
            splat_count++;
    endtask

    always @(posedge clk)
    begin
        cell_read_t exp_read;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("kde_4d_grid_splat_unit: mismatch");
            $finish;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken = 1'b1;
                accepted++;
                if (on_bus.kind == REQ_SPLAT)
                    splat_point(on_bus);
                else
                begin
                    exp_read.value = (longint'(on_bus.cidx) < TOTAL_CELLS) ?
                                     density[on_bus.cidx] : 32'd0;
                    exp_read.count = splat_count;
                    expected_reads.push_back(exp_read);
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_reads.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
                    failed = 1'b1;
                end
                else
                begin
                    exp_read = expected_reads.pop_front();
                    if (m_axis_tdata[31:0] !== exp_read.value)
                    begin
                        $display("%0t: cell_value expected %h actual %h",
                                 $time, exp_read.value, m_axis_tdata[31:0]);
                        failed = 1'b1;
                    end
                    if (m_axis_tdata[63:32] !== exp_read.count)
                    begin
                        $display("%0t: point_count expected %h actual %h",
                                 $time, exp_read.count, m_axis_tdata[63:32]);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!s_axis_tvalid || taken)
        begin
            taken = 1'b0;
            if (pending_requests.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 28))
            begin
                on_bus = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= on_bus.kind;
                s_axis_tdata  <= {on_bus.cidx, on_bus.y2, on_bus.x2, on_bus.y1, on_bus.x1};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= no_gaps || $urandom_range(0, 99) >= 28;
    end

    task automatic queue_request(logic kind, logic [31:0] x1, logic [31:0] y1,
                                 logic [31:0] x2, logic [31:0] y2, logic [15:0] cidx);
        request_t rq;
        rq = '{kind, x1, y1, x2, y2, cidx};
        pending_requests.push_back(rq);
        queued++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        #1;
        while (!cfg_ready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        case (idx)
            CFG_ORIGIN_X1: org_x1 = value;
            CFG_ORIGIN_Y1: org_y1 = value;
            CFG_ORIGIN_X2: org_x2 = value;
            CFG_ORIGIN_Y2: org_y2 = value;
            CFG_CELL_SIZE: cell_len = value[30:0];
            CFG_BANDWIDTH: band = value[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [31:0] ox1, logic [31:0] oy1, logic [31:0] ox2,
                             logic [31:0] oy2, logic [31:0] cs, logic [31:0] bw);
        cfg_write(CFG_ORIGIN_X1, ox1);
        cfg_write(CFG_ORIGIN_Y1, oy1);
        cfg_write(CFG_ORIGIN_X2, ox2);
        cfg_write(CFG_ORIGIN_Y2, oy2);
        cfg_write(CFG_CELL_SIZE, cs);
        cfg_write(CFG_BANDWIDTH, bw);
    endtask

    function automatic logic [31:0] near_coord(logic [31:0] org, logic [3:0] c);
        return org + {1'b0, cell_len} * c + $urandom_range(0, cell_len);
    endfunction

    task automatic random_requests(int n, int splat_pct, bit noise);
        logic [3:0] c[4];
        logic [15:0] cidx;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < splat_pct)
            begin
                foreach (c[k])
                    c[k] = 4'($urandom_range(0, 15));
                recent_cell = {c[3], c[2], c[1], c[0]};
                if (noise && $urandom_range(0, 3) == 0)
                    queue_request(REQ_SPLAT, $urandom, $urandom, $urandom, $urandom,
                                  16'($urandom));
                else
                    queue_request(REQ_SPLAT, near_coord(org_x1, c[0]), near_coord(org_y1, c[1]),
                                  near_coord(org_x2, c[2]), near_coord(org_y2, c[3]),
                                  16'($urandom));
            end
            else
            begin
                cidx = recent_cell;
                foreach (c[k])
                    cidx[4*k +: 4] = 4'(cidx[4*k +: 4] + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 9) < 4)
                    cidx = 16'($urandom);
                queue_request(REQ_READ, $urandom, $urandom, $urandom, $urandom, cidx);
            end
        end
        queue_request(REQ_READ, $urandom, $urandom, $urandom, $urandom, recent_cell);
    endtask

    task automatic drain;
        while (accepted != queued || expected_reads.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < GRID_DEPTH; i++)
            density[i] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        configure(32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd131072);
        queue_request(REQ_SPLAT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
        queue_request(REQ_READ, '0, '0, '0, '0, 16'd0);
        queue_request(REQ_SPLAT, 32'h0002_0000, 32'h0000_0000, 32'h0005_0000, 32'h0005_0000, 0);
        queue_request(REQ_READ, '0, '0, '0, '0, 16'h5500);
        queue_request(REQ_READ, '0, '0, '0, '0, 16'h5501);
        queue_request(REQ_SPLAT, 32'h0007_8000, 32'h0008_4000, 32'h000A_C000, 32'h0003_2000, 0);
        queue_request(REQ_READ, '0, '0, '0, '0, 16'h3A87);
        queue_request(REQ_READ, '0, '0, '0, '0, 16'h3B88);
        queue_request(REQ_SPLAT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        queue_request(REQ_SPLAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 0);
        queue_request(REQ_READ, '0, '0, '0, '0, 16'hFFFF);
        queue_request(REQ_READ, '0, '0, '0, '0, 16'hFF0F);
        queue_request(REQ_SPLAT, 32'h000F_0000, 32'h000F_0000, 32'h000F_0000, 32'h000F_0000, 0);
        queue_request(REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      16'hFFFF);
        queue_request(REQ_READ, '0, '0, '0, '0, 16'hEEEE);
        queue_request(REQ_READ, '0, '0, '0, '0, 16'h0001);
        random_requests(300, 35, 1'b0);
        drain();

        configure(32'hFFF8_0000, 32'hFFF8_0000, 32'hFFF8_0000, 32'hFFF8_0000,
                  32'd32768, 32'd98304);
        no_gaps = 1'b1;
        random_requests(280, 30, 1'b0);
        drain();
        no_gaps = 1'b0;

        configure(32'h7FF0_0000, 32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF, 32'd1, 32'd3);
        random_requests(250, 30, 1'b1);
        drain();

        configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_requests(30, 40, 1'b1);
        drain();

        configure(32'h4000_0000, 32'hC000_0000, 32'h0001_0000, 32'hFFFE_0000,
                  32'd196608, 32'd65536);
        random_requests(220, 30, 1'b1);
        drain();

        if (!failed)
            $display("kde_4d_grid_splat_unit: match");
        else
            $display("kde_4d_grid_splat_unit: mismatch");
        $finish;
    end
endmodule
